[sv/ucs_pkg.sv]
// Shared types, codes and constants for the URI component splitter.
`timescale 1ns / 1ps

package ucs_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_SCHEME = 3'd0;
  localparam logic [2:0] PH_SLASH1 = 3'd1;
  localparam logic [2:0] PH_SLASH2 = 3'd2;
  localparam logic [2:0] PH_AUTH   = 3'd3;
  localparam logic [2:0] PH_PATH   = 3'd4;
  localparam logic [2:0] PH_QUERY  = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  // Part tags
  localparam logic [2:0] PART_NONE   = 3'd0;
  localparam logic [2:0] PART_SCHEME = 3'd1;
  localparam logic [2:0] PART_AUTH   = 3'd2;
  localparam logic [2:0] PART_PATH   = 3'd3;
  localparam logic [2:0] PART_QUERY  = 3'd4;

  // Delimiters
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;

  localparam logic [2:0] SCHEME_HTTP_LEN = 3'd4;
  localparam logic [2:0] SCHEME_LEN_MAX  = 3'd5;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] scheme_len;
    logic       scheme_mismatch;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [2:0] part;
    logic       done_res;
    logic       bad_request;
  } parse_result_t;

  // Letters of the only scheme accepted
  function automatic logic [7:0] http_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h68; // h
      2'd1:    c = 8'h74; // t
      2'd2:    c = 8'h74; // t
      default: c = 8'h70; // p
    endcase
    return c;
  endfunction

endpackage

[sv/ucs_step.sv]
// Next-state and result logic for one URI byte.
`timescale 1ns / 1ps

module ucs_step (
  input  ucs_pkg::parse_state_t  state_i,
  input  logic [7:0]             ch_i,
  output ucs_pkg::parse_state_t  state_o,
  output ucs_pkg::parse_result_t result_o
);
  import ucs_pkg::*;

  logic       is_upper;
  logic       is_lower;
  logic       is_extra;
  logic [7:0] lc_char;
  logic       push;
  logic [7:0] push_char;
  logic       term_bad;

  assign is_upper = (ch_i >= 8'h41) && (ch_i <= 8'h5A);
  assign is_lower = (ch_i >= 8'h61) && (ch_i <= 8'h7A);
  assign is_extra = ((ch_i >= 8'h30) && (ch_i <= 8'h39)) || (ch_i == CH_PLUS) ||
                    (ch_i == CH_MINUS) || (ch_i == CH_DOT);
  assign lc_char  = is_upper ? (ch_i + 8'd32) : ch_i;
  assign push_char = lc_char;

  // Bad at terminator: path never reached, or a scheme other than http
  assign term_bad = ((state_i.phase != PH_PATH) && (state_i.phase != PH_QUERY)) ||
                    ((state_i.scheme_len != 3'd0) &&
                     (state_i.scheme_mismatch || (state_i.scheme_len != SCHEME_HTTP_LEN)));

  always_comb begin
    logic [2:0] phase_n;
    logic [2:0] part_n;
    phase_n = state_i.phase;
    part_n  = PART_NONE;
    push    = 1'b0;
    unique case (state_i.phase)
      PH_SCHEME: begin
        if (ch_i == CH_SLASH) begin
          if (state_i.scheme_len == 3'd0) begin
            part_n  = PART_PATH;
            phase_n = PH_PATH;
          end else begin
            phase_n = PH_ERROR;
          end
        end else if (ch_i == CH_COLON) begin
          phase_n = PH_SLASH1;
        end else if (is_upper || is_lower) begin
          push   = 1'b1;
          part_n = PART_SCHEME;
        end else if (is_extra) begin
          if (state_i.scheme_len == 3'd0) begin
            phase_n = PH_ERROR;
          end else begin
            push   = 1'b1;
            part_n = PART_SCHEME;
          end
        end else begin
          phase_n = PH_ERROR;
        end
      end
      PH_SLASH1: phase_n = (ch_i == CH_SLASH) ? PH_SLASH2 : PH_ERROR;
      PH_SLASH2: phase_n = (ch_i == CH_SLASH) ? PH_AUTH : PH_ERROR;
      PH_AUTH: begin
        if (ch_i == CH_SLASH) begin
          part_n  = PART_PATH;
          phase_n = PH_PATH;
        end else begin
          part_n = PART_AUTH;
        end
      end
      PH_PATH: begin
        if (ch_i == CH_QUESTION) begin
          phase_n = PH_QUERY;
        end else begin
          part_n = PART_PATH;
        end
      end
      PH_QUERY: part_n = PART_QUERY;
      default:  phase_n = PH_ERROR;
    endcase

    state_o = state_i;
    state_o.phase = phase_n;
    if (push) begin
      if (state_i.scheme_len < SCHEME_HTTP_LEN) begin
        if (push_char != http_char(state_i.scheme_len[1:0])) begin
          state_o.scheme_mismatch = 1'b1;
        end
      end else begin
        state_o.scheme_mismatch = 1'b1;
      end
      if (state_i.scheme_len < SCHEME_LEN_MAX) begin
        state_o.scheme_len = state_i.scheme_len + 3'd1;
      end
    end

    result_o.done_res = 1'b0;
    if (phase_n == PH_ERROR) begin
      result_o.out_char    = ch_i;
      result_o.part        = PART_NONE;
      result_o.bad_request = 1'b1;
    end else begin
      // Lowercase scheme bytes only; every other byte passes as it is
      result_o.out_char    = push ? lc_char : ch_i;
      result_o.part        = part_n;
      result_o.bad_request = 1'b0;
    end

    // Terminator: report and return to the start of a URI
    if (ch_i == CH_NUL) begin
      state_o.phase           = PH_SCHEME;
      state_o.scheme_len      = 3'd0;
      state_o.scheme_mismatch = 1'b0;
      result_o.out_char       = CH_NUL;
      result_o.part           = PART_NONE;
      result_o.done_res       = 1'b1;
      result_o.bad_request    = term_bad;
    end
  end

endmodule

[sv/uri_component_splitter.sv]
// Top level of the URI component splitter: parse state and result register.
`timescale 1ns / 1ps

// Takes a request URI one byte per item (byte 0 ends it) and returns one result
// item per byte: the byte (scheme letters lowercased), its part tag (scheme,
// authority, path, query, or none for a dropped delimiter), a done flag on the
// terminator and a sticky bad-request flag. The parse state updates at
// acceptance and the result is held in a single output register, so a new
// byte is accepted every cycle while the output is taken; the result is valid
// in the cycle after acceptance. The parse state is the only loop through the
// step logic.
module uri_component_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [2:0] part_o,
  output logic       done_res_o,
  output logic       bad_request_o
);
  import ucs_pkg::*;

  parse_state_t  state_q, state_d;
  parse_result_t result_q, result_d;
  logic          out_valid_q;
  logic          in_accept;

  // Hold the input while a finished item waits on a stalled output
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  ucs_step u_step (
    .state_i  (state_q),
    .ch_i     (ch_i),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Advance the parse state on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase           <= PH_SCHEME;
      state_q.scheme_len      <= 3'd0;
      state_q.scheme_mismatch <= 1'b0;
      out_valid_q             <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: load whenever an item is accepted
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = result_q.out_char;
  assign part_o        = result_q.part;
  assign done_res_o    = result_q.done_res;
  assign bad_request_o = result_q.bad_request;

endmodule
